[sv/gee_pkg.sv]
`default_nettype none

package gee_pkg;

    localparam int ROW_MAX = 1024;
    localparam int COL_W   = $clog2(ROW_MAX);
    localparam int LEN_W   = 11;
    localparam int ROW_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int QDEPTH  = 2;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;

    typedef enum logic [2:0] {
        REG_DIAG = 3'd0,
        REG_ROWC = 3'd1,
        REG_COLC = 3'd2,
        REG_AREA = 3'd3,
        REG_LEN  = 3'd4,
        REG_CNT  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [ROW_W-1:0] cnt;
    } t_grid_cfg;

    typedef struct packed {
        logic [31:0] diag;
        logic [31:0] rowc;
        logic [31:0] colc;
        logic [31:0] area;
    } t_coef;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic [31:0] pot;
        logic [31:0] left;
        logic [31:0] up;
        logic        has_left;
        logic        has_up;
        logic        last;
    } t_job;

    typedef struct packed {
        logic [63:0] q;
        logic        big;
    } t_scaled;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RR,
        ST_II,
        ST_LR,
        ST_LI,
        ST_UR,
        ST_UI,
        ST_DG,
        ST_PT,
        ST_CL,
        ST_RW,
        ST_NM,
        ST_E0,
        ST_E1,
        ST_N0,
        ST_N1,
        ST_OUT
    } t_step;

endpackage

`default_nettype wire

[sv/gee_front.sv]
`default_nettype none

module gee_front import gee_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_grid_cfg   i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_re,
    input  logic [15:0] i_im,
    input  logic [31:0] i_pot,
    input  logic        i_q_ready,
    output logic        o_push,
    output t_job        o_job
);

    logic [31:0]      r_mem [ROW_MAX];
    logic [31:0]      r_up;
    logic [31:0]      r_left;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_hvalid;
    t_job             r_hjob;

    logic             w_accept;
    logic [31:0]      w_packed;
    logic             w_row_end;
    logic             w_last;

    assign o_ready   = !r_hvalid || i_q_ready;
    assign w_accept  = i_valid && o_ready;
    assign w_packed  = {i_im, i_re};
    assign w_row_end = (LEN_W'(r_col) + LEN_W'(1)) >= i_cfg.len;
    assign w_last    = w_row_end && (({1'b0, r_row} + (ROW_W+1)'(1)) >= {1'b0, i_cfg.cnt});

    // read-first row buffer: the sample one row above comes out as this one goes in
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_col] <= w_packed;
            r_up         <= r_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
        end else begin
            r_hvalid <= w_accept || (r_hvalid && !i_q_ready);
            if (w_accept) begin
                if (w_last) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_left <= '0;
                end else begin
                    r_left <= w_packed;
                    if (w_row_end) begin
                        r_col <= '0;
                        r_row <= r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hjob.re       <= i_re;
            r_hjob.im       <= i_im;
            r_hjob.pot      <= i_pot;
            r_hjob.left     <= r_left;
            r_hjob.up       <= '0;
            r_hjob.has_left <= (r_col != '0);
            r_hjob.has_up   <= (r_row != '0);
            r_hjob.last     <= w_last;
        end
    end

    assign o_push = r_hvalid;

    always_comb begin
        o_job    = r_hjob;
        o_job.up = r_up;
    end

endmodule

`default_nettype wire

[sv/gee_queue.sv]
`default_nettype none

module gee_queue import gee_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job           r_slot [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_ready = (r_cnt != QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[sv/gee_back.sv]
`default_nettype none

module gee_back import gee_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_coef       i_coef,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [63:0] o_energy,
    output logic [62:0] o_norm,
    output logic        o_ovf
);

    function automatic t_scaled scale_mag(input logic [63:0] p1, input logic [63:0] p0,
                                          input logic neg);
        logic [64:0] q;
        t_scaled     r;
        q = {2'b00, p1[46:0], 16'h0000} + {17'd0, p0[63:16]}
            + {64'd0, neg & (|p0[15:0])};
        r.big = (|p1[63:47]) || q[64] || (q[63] && (|q[62:0]));
        r.q   = q[63:0];
        return r;
    endfunction

    t_step              r_state;
    t_step              n_state;
    t_job               r_job;
    logic signed [PROD_W-1:0] r_prod;
    logic [31:0]        r_mag;
    logic signed [32:0] r_dl;
    logic signed [32:0] r_du;
    logic signed [63:0] r_esum;
    logic [62:0]        r_nsum;
    logic               r_sat;
    logic [63:0]        r_p0;
    logic [63:0]        r_eres;
    logic               r_eflag;
    logic               r_ovalid;
    logic [63:0]        r_oenergy;
    logic [62:0]        r_onorm;
    logic               r_oovf;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [63:0]       e_term;
    logic                     e_en;

    logic signed [MUL_W-1:0]  w_re, w_im, w_lre, w_lim, w_ure, w_uim, w_pot;
    logic signed [PROD_W-1:0] w_sh14;
    logic signed [PROD_W-1:0] w_sh13;
    logic [63:0]              w_neg13;
    logic [64:0]              w_esum;
    logic                     w_eovf;
    logic [63:0]              w_esat;
    logic [63:0]              w_nsum;
    logic                     w_nsat;
    logic                     w_eneg;
    logic [63:0]              w_emag;
    logic                     w_oslot;
    t_scaled                  w_es;
    t_scaled                  w_ns;
    logic [63:0]              w_eval;
    logic                     w_ebig;
    logic                     w_nbig;

    assign w_re  = {{17{r_job.re[15]}}, r_job.re};
    assign w_im  = {{17{r_job.im[15]}}, r_job.im};
    assign w_lre = {{17{r_job.left[15]}}, r_job.left[15:0]};
    assign w_lim = {{17{r_job.left[31]}}, r_job.left[31:16]};
    assign w_ure = {{17{r_job.up[15]}}, r_job.up[15:0]};
    assign w_uim = {{17{r_job.up[31]}}, r_job.up[31:16]};
    assign w_pot = {r_job.pot[31], r_job.pot};

    assign w_prod  = mul_a * mul_b;
    assign w_sh14  = r_prod >>> 14;
    assign w_sh13  = r_prod >>> 13;
    assign w_neg13 = 64'd0 - w_sh13[63:0];

    // saturating energy accumulate
    assign w_esum = {e_term[63], e_term} + {r_esum[63], r_esum};
    assign w_eovf = (w_esum[64] != w_esum[63]);
    assign w_esat = w_eovf ? (w_esum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                           : w_esum[63:0];

    assign w_nsum = {1'b0, r_nsum} + {30'd0, r_mag, 2'b00};
    assign w_nsat = w_nsum[63];

    assign w_eneg = r_esum[63];
    assign w_emag = w_eneg ? (64'd0 - unsigned'(r_esum)) : unsigned'(r_esum);

    // final scale: partial products arrive low half first
    assign w_es = scale_mag(r_prod[63:0], r_p0, w_eneg);
    assign w_ns = scale_mag(r_prod[63:0], r_p0, 1'b0);

    always_comb begin
        if (w_eneg) begin
            w_ebig = w_es.big;
            w_eval = w_es.big ? 64'h8000_0000_0000_0000 : (64'd0 - w_es.q);
        end else begin
            w_ebig = w_es.big || w_es.q[63];
            w_eval = w_ebig ? 64'h7FFF_FFFF_FFFF_FFFF : w_es.q;
        end
    end

    assign w_nbig  = w_ns.big || w_ns.q[63];
    assign w_oslot = !r_ovalid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_RR;
            ST_RR:   n_state = ST_II;
            ST_II:   n_state = ST_LR;
            ST_LR:   n_state = ST_LI;
            ST_LI:   n_state = ST_UR;
            ST_UR:   n_state = ST_UI;
            ST_UI:   n_state = ST_DG;
            ST_DG:   n_state = ST_PT;
            ST_PT:   n_state = ST_CL;
            ST_CL:   n_state = ST_RW;
            ST_RW:   n_state = ST_NM;
            ST_NM:   n_state = r_job.last ? ST_E0 : ST_IDLE;
            ST_E0:   n_state = ST_E1;
            ST_E1:   n_state = ST_N0;
            ST_N0:   n_state = ST_N1;
            ST_N1:   n_state = ST_OUT;
            ST_OUT:  if (w_oslot) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        e_term  = '0;
        e_en    = 1'b0;
        o_q_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: o_q_pop = i_q_valid;
            ST_RR: begin
                mul_a = w_re;
                mul_b = w_re;
            end
            ST_II: begin
                mul_a = w_im;
                mul_b = w_im;
            end
            ST_LR: begin
                mul_a = w_lre;
                mul_b = w_re;
            end
            ST_LI: begin
                mul_a = w_lim;
                mul_b = w_im;
            end
            ST_UR: begin
                mul_a = w_ure;
                mul_b = w_re;
            end
            ST_UI: begin
                mul_a = w_uim;
                mul_b = w_im;
            end
            ST_DG: begin
                mul_a = {1'b0, i_coef.diag};
                mul_b = {1'b0, r_mag};
            end
            ST_PT: begin
                mul_a  = w_pot;
                mul_b  = {1'b0, r_mag};
                e_term = w_sh14[63:0];
                e_en   = 1'b1;
            end
            ST_CL: begin
                mul_a  = {1'b0, i_coef.colc};
                mul_b  = r_dl;
                e_term = w_sh14[63:0];
                e_en   = 1'b1;
            end
            ST_RW: begin
                mul_a  = {1'b0, i_coef.rowc};
                mul_b  = r_du;
                e_term = w_neg13;
                e_en   = r_job.has_left;
            end
            ST_NM: begin
                e_term = w_neg13;
                e_en   = r_job.has_up;
            end
            ST_E0: begin
                mul_a = {1'b0, w_emag[31:0]};
                mul_b = {1'b0, i_coef.area};
            end
            ST_E1: begin
                mul_a = {1'b0, w_emag[63:32]};
                mul_b = {1'b0, i_coef.area};
            end
            ST_N0: begin
                mul_a = {1'b0, r_nsum[31:0]};
                mul_b = {1'b0, i_coef.area};
            end
            ST_N1, ST_OUT: begin
                mul_a = {2'b00, r_nsum[62:32]};
                mul_b = {1'b0, i_coef.area};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_esum   <= '0;
            r_nsum   <= '0;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (e_en) begin
                r_esum <= w_esat;
            end
            if (r_state == ST_NM) begin
                r_nsum <= w_nsat ? {63{1'b1}} : w_nsum[62:0];
            end
            if ((e_en && w_eovf) || ((r_state == ST_NM) && w_nsat)) begin
                r_sat <= 1'b1;
            end
            if ((r_state == ST_OUT) && w_oslot) begin
                r_esum   <= '0;
                r_nsum   <= '0;
                r_sat    <= 1'b0;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        unique case (r_state)
            ST_II: r_mag <= r_prod[31:0];
            ST_LR: r_mag <= r_mag + r_prod[31:0];
            ST_LI: r_dl  <= r_prod[32:0];
            ST_UR: r_dl  <= r_dl + r_prod[32:0];
            ST_UI: r_du  <= r_prod[32:0];
            ST_DG: r_du  <= r_du + r_prod[32:0];
            ST_E1: r_p0  <= r_prod[63:0];
            ST_N0: begin
                r_eres  <= w_eval;
                r_eflag <= r_sat || w_ebig;
            end
            ST_N1: r_p0  <= r_prod[63:0];
            ST_OUT: begin
                if (w_oslot) begin
                    r_oenergy <= r_eres;
                    r_onorm   <= w_nbig ? {63{1'b1}} : w_ns.q[62:0];
                    r_oovf    <= r_eflag || w_nbig;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_energy    = r_oenergy;
    assign o_norm      = r_onorm;
    assign o_ovf       = r_oovf;

endmodule

`default_nettype wire

[sv/grid_energy_expectation.sv]
// Energy expectation and norm of a complex wavefunction on a 2D grid under the five-point
// finite-difference Hamiltonian. Samples arrive in raster order, one per transaction, with
// their potential; after the last sample of the grid one transaction carries the
// cell-area-scaled energy (signed Q32.32), the norm (Q31.32) and a flag set if any sum
// or the final scaling saturated during the pass. Rows hold 2 to 1024 samples. The front
// accepts a sample every cycle while the two-entry queue has room; the back steps each
// sample through one shared 33x33 multiplier (ST_RR to ST_NM) and pops no new one before
// it is done; the grid's last sample then adds ST_E0 to ST_OUT for the final scaling. Write
// registers only while no sample is in flight; new values apply from the next sample on.
`default_nettype none

module grid_energy_expectation import gee_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // psi_re[15:0], psi_im[31:16], potential[63:32]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // energy[63:0], norm[126:64], overflow[127]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0]      r_diag;
    logic [31:0]      r_rowc;
    logic [31:0]      r_colc;
    logic [31:0]      r_area;
    logic [LEN_W-1:0] r_len;
    logic [ROW_W-1:0] r_cnt;

    t_reg_idx  w_idx;
    logic      w_wr;
    t_grid_cfg w_cfg;
    t_coef     w_coef;

    logic      w_push;
    logic      w_q_ready;
    t_job      w_front_job;
    logic      w_q_valid;
    t_job      w_q_job;
    logic      w_pop;
    logic [63:0] w_energy;
    logic [62:0] w_norm;
    logic        w_ovf;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag <= '0;
            r_rowc <= '0;
            r_colc <= '0;
            r_area <= '0;
            r_len  <= LEN_W'(2);
            r_cnt  <= ROW_W'(2);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DIAG: r_diag <= pwdata;
                REG_ROWC: r_rowc <= pwdata;
                REG_COLC: r_colc <= pwdata;
                REG_AREA: r_area <= pwdata;
                REG_LEN:  r_len  <= pwdata[LEN_W-1:0];
                REG_CNT:  r_cnt  <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DIAG: prdata = r_diag;
            REG_ROWC: prdata = r_rowc;
            REG_COLC: prdata = r_colc;
            REG_AREA: prdata = r_area;
            REG_LEN:  prdata = {{(32-LEN_W){1'b0}}, r_len};
            REG_CNT:  prdata = {{(32-ROW_W){1'b0}}, r_cnt};
            default:  prdata = '0;
        endcase
    end

    // out-of-range lengths and counts clamp
    always_comb begin
        priority if (r_len < LEN_W'(2)) begin
            w_cfg.len = LEN_W'(2);
        end else if (r_len > LEN_W'(ROW_MAX)) begin
            w_cfg.len = LEN_W'(ROW_MAX);
        end else begin
            w_cfg.len = r_len;
        end
        w_cfg.cnt = (r_cnt < ROW_W'(2)) ? ROW_W'(2) : r_cnt;
    end

    assign w_coef.diag = r_diag;
    assign w_coef.rowc = r_rowc;
    assign w_coef.colc = r_colc;
    assign w_coef.area = r_area;

    gee_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_re      (s_axis_tdata[15:0]),
        .i_im      (s_axis_tdata[31:16]),
        .i_pot     (s_axis_tdata[63:32]),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_job     (w_front_job)
    );

    gee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_pop   (w_pop)
    );

    gee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coef      (w_coef),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_q_job),
        .o_q_pop     (w_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_energy    (w_energy),
        .o_norm      (w_norm),
        .o_ovf       (w_ovf)
    );

    assign m_axis_tdata = {w_ovf, w_norm, w_energy};

endmodule

`default_nettype wire
